// File: rtl/hspf_pkg.sv
// ----------------------------------------------------------------------------
// hspf_pkg
// shared types, constants and helpers of the hamming subspace prune filter
// ----------------------------------------------------------------------------
package hspf_pkg;

    // code geometry
    localparam int CODE_BITS     = 64;
    localparam int MAX_SUBSPACES = 32;

    // fixed field widths
    localparam int ROW_W   = 32;
    localparam int WORD_W  = 64;
    localparam int IDX_W   = 5;
    localparam int RAD_W   = 7;
    localparam int SAMP_W  = 7;
    localparam int NSUB_W  = 6;
    localparam int OUT_W   = 7;
    localparam int CFG_IDX_W = 2;

    // derived internal widths
    localparam int PC_W    = $clog2(CODE_BITS + 1);
    localparam int SUM_RAW = $clog2(MAX_SUBSPACES * CODE_BITS + 1);
    localparam int SUM_W   = (SUM_RAW > OUT_W + 1) ? SUM_RAW : OUT_W + 1;
    localparam int PROD_W  = SUM_W + RAD_W;
    localparam int STAGE_ID_W = 7;

    // verdict codes
    localparam logic [1:0] VERDICT_PRUNED    = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT    = 2'd1;
    localparam logic [1:0] VERDICT_DEFER     = 2'd2;
    localparam logic [1:0] VERDICT_UNDECIDED = 2'd3;

    // item function codes
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUBSPACES = 2'd3;

    // configuration reset values
    localparam logic [RAD_W-1:0]  RADIUS_RST        = 7'd20;
    localparam logic [SAMP_W-1:0] SAMPLE_COUNT_RST  = 7'd64;
    localparam logic [NSUB_W-1:0] NUM_SUBSPACES_RST = 6'd20;

    typedef struct packed {
        logic              func;
        logic [ROW_W-1:0]  row_id;
        logic [WORD_W-1:0] data_word;
        logic [IDX_W-1:0]  mask_index;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] result_row;
        logic [1:0]       verdict;
        logic [OUT_W-1:0] partial_distance;
        logic [OUT_W-1:0] bits_checked;
        logic [OUT_W-1:0] exact_distance;
        logic             within_radius;
    } result_t;

    // payload carried down the subspace pipeline
    typedef struct packed {
        logic                 is_load;
        logic [ROW_W-1:0]     row;
        logic [CODE_BITS-1:0] word;
        logic [IDX_W-1:0]     idx;
        logic [SUM_W-1:0]     hc;
        logic [SUM_W-1:0]     bc;
        logic                 decided;
        logic [1:0]           verdict;
        logic [PC_W-1:0]      exact;
    } stage_t;

    function automatic logic [PC_W-1:0] popcount(input logic [CODE_BITS-1:0] v);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < CODE_BITS; i++)
        begin
            n = n + PC_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [OUT_W-1:0] sat7(input logic [SUM_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > SUM_W'({OUT_W{1'b1}}))
        begin
            r = {OUT_W{1'b1}};
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/hamming_subspace_prune_filter_core.sv
// ----------------------------------------------------------------------------
// hamming_subspace_prune_filter_core
// streaming hamming range filter with ordered subspace pruning
// ----------------------------------------------------------------------------
//
//  channel   signals                                   width   role
//  item      item_valid, item_stall, item_data         1+1+102 scan code or mask load
//  result    result_valid, result_stall, result_data   1+1+56  one verdict per scan
//  config    cfg_wr_en, cfg_index, cfg_wdata           1+2+64  register writes
//
//  one item enters per cycle while item_stall is low; a scan result passes
//  through the entry register, one pipeline stage per subspace and the
//  output register. load items produce no result.
//  reset clears config to its reset values, all subspace masks to zero and
//  every stage valid bit. a stalled result freezes the whole pipeline, so
//  item_stall rises in the same cycle.
//
module hamming_subspace_prune_filter_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                item_valid,
    output logic                                item_stall,
    input  hspf_pkg::item_t                     item_data,

    output logic                                result_valid,
    input  logic                                result_stall,
    output hspf_pkg::result_t                   result_data,

    input  logic                                cfg_wr_en,
    input  logic [hspf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hspf_pkg::WORD_W-1:0]         cfg_wdata
);

    localparam int NS = hspf_pkg::MAX_SUBSPACES;
    localparam int CB = hspf_pkg::CODE_BITS;

    // configuration registers
    logic [CB-1:0]                   query_reg;
    logic [hspf_pkg::RAD_W-1:0]      radius_reg;
    logic [hspf_pkg::SAMP_W-1:0]     sample_reg;
    logic [hspf_pkg::NSUB_W-1:0]     nsub_reg;

    // pipeline: entry register, one register per subspace stage
    logic                            pv_reg [0:NS];
    hspf_pkg::stage_t                pd_reg [0:NS];

    // output register
    logic                            result_valid_reg;
    hspf_pkg::result_t               result_data_reg;

    // whole pipeline moves when the output slot is free or being taken
    logic                            advance;
    logic [CB-1:0]                   entry_word;
    hspf_pkg::stage_t                entry_next;

    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = !advance;

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg  <= '0;
            radius_reg <= hspf_pkg::RADIUS_RST;
            sample_reg <= hspf_pkg::SAMPLE_COUNT_RST;
            nsub_reg   <= hspf_pkg::NUM_SUBSPACES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hspf_pkg::CFG_QUERY_CODE:    query_reg  <= cfg_wdata[CB-1:0];
                hspf_pkg::CFG_RADIUS:        radius_reg <= cfg_wdata[hspf_pkg::RAD_W-1:0];
                hspf_pkg::CFG_SAMPLE_COUNT:  sample_reg <= cfg_wdata[hspf_pkg::SAMP_W-1:0];
                hspf_pkg::CFG_NUM_SUBSPACES: nsub_reg   <= cfg_wdata[hspf_pkg::NSUB_W-1:0];
                default:                     query_reg  <= query_reg;
            endcase
        end
    end

    // entry: xor with the query for scans, raw mask bits for loads
    always_comb
    begin
        if (item_data.func == hspf_pkg::FUNC_LOAD)
        begin
            entry_word = item_data.data_word[CB-1:0];
        end
        else
        begin
            entry_word = item_data.data_word[CB-1:0] ^ query_reg;
        end
        entry_next.is_load = (item_data.func == hspf_pkg::FUNC_LOAD);
        entry_next.row     = item_data.row_id;
        entry_next.word    = entry_word;
        entry_next.idx     = item_data.mask_index;
        entry_next.hc      = '0;
        entry_next.bc      = '0;
        entry_next.decided = 1'b0;
        entry_next.verdict = hspf_pkg::VERDICT_UNDECIDED;
        entry_next.exact   = hspf_pkg::popcount(entry_word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            pv_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pd_reg[0] <= entry_next;
        end
    end

    // one stage per subspace; each stage owns its mask, so a load lands
    // in order with the scans around it
    for (genvar g = 0; g < NS; g++)
    begin : g_sub
        localparam logic [hspf_pkg::STAGE_ID_W-1:0] STAGE_ID =
            hspf_pkg::STAGE_ID_W'(g);

        logic [CB-1:0]                 mask_reg;
        logic [hspf_pkg::PC_W-1:0]     mpc_reg;
        logic [hspf_pkg::PC_W-1:0]     h;
        logic [hspf_pkg::SUM_W-1:0]    hc_n;
        logic [hspf_pkg::SUM_W-1:0]    bc_n;
        logic [hspf_pkg::PROD_W-1:0]   lhs;
        logic [hspf_pkg::PROD_W-1:0]   rhs;
        logic                          walked;
        logic                          load_hit;
        hspf_pkg::stage_t              cur;
        hspf_pkg::stage_t              nxt;

        assign cur    = pd_reg[g];
        assign h      = hspf_pkg::popcount(cur.word & mask_reg);
        assign hc_n   = cur.hc + hspf_pkg::SUM_W'(h);
        assign bc_n   = cur.bc + hspf_pkg::SUM_W'(mpc_reg);
        // exact cross-multiplied form of the distance estimate
        assign lhs    = hspf_pkg::PROD_W'(hc_n) * hspf_pkg::PROD_W'(CB);
        assign rhs    = hspf_pkg::PROD_W'(radius_reg) * hspf_pkg::PROD_W'(bc_n);
        assign walked = hspf_pkg::STAGE_ID_W'(nsub_reg) > STAGE_ID;
        assign load_hit = pv_reg[g] && cur.is_load
                       && (hspf_pkg::STAGE_ID_W'(cur.idx) == STAGE_ID);

        always_comb
        begin
            nxt = cur;
            if (!cur.is_load && !cur.decided && walked)
            begin
                nxt.hc = hc_n;
                nxt.bc = bc_n;
                if (hc_n > hspf_pkg::SUM_W'(radius_reg))
                begin
                    nxt.decided = 1'b1;
                    nxt.verdict = hspf_pkg::VERDICT_PRUNED;
                end
                else if (bc_n >= hspf_pkg::SUM_W'(sample_reg))
                begin
                    nxt.decided = 1'b1;
                    nxt.verdict = (lhs <= rhs) ? hspf_pkg::VERDICT_ACCEPT
                                               : hspf_pkg::VERDICT_PRUNED;
                end
                else if (h <= hspf_pkg::PC_W'(1))
                begin
                    nxt.decided = 1'b1;
                    nxt.verdict = hspf_pkg::VERDICT_DEFER;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mask_reg   <= '0;
                mpc_reg    <= '0;
                pv_reg[g+1] <= 1'b0;
            end
            else if (advance)
            begin
                pv_reg[g+1] <= pv_reg[g];
                if (load_hit)
                begin
                    mask_reg <= cur.word;
                    mpc_reg  <= hspf_pkg::popcount(cur.word);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                pd_reg[g+1] <= nxt;
            end
        end
    end

    // output register: scans only, loads retire silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= pv_reg[NS] && !pd_reg[NS].is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_data_reg.result_row       <= pd_reg[NS].row;
            result_data_reg.verdict          <= pd_reg[NS].verdict;
            result_data_reg.partial_distance <= hspf_pkg::sat7(pd_reg[NS].hc);
            result_data_reg.bits_checked     <= hspf_pkg::sat7(pd_reg[NS].bc);
            result_data_reg.exact_distance   <= hspf_pkg::OUT_W'(pd_reg[NS].exact);
            result_data_reg.within_radius    <=
                hspf_pkg::OUT_W'(pd_reg[NS].exact) <= radius_reg;
        end
    end

endmodule
